@@ rtl/spsc_pkg.sv @@
// Package with the shared types, opcodes and coil table of the stepper step controller.
`timescale 1ns / 1ps
`default_nettype none

package spsc_pkg;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_PORT_WRITE = 3'd1,
    OP_SET_PERIOD = 3'd2,
    OP_SET_RUN    = 3'd3,
    OP_LOAD_TGT   = 3'd4,
    OP_NOP        = 3'd5
  } opcode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] payload;
    logic        clear_counters;
  } item_t;

  localparam logic [23:0] PERIOD_RESET = 24'd520;
  localparam logic [7:0]  PORT_RESET   = 8'h80;
  localparam int unsigned RUN_BIT      = 7;
  localparam int unsigned DIR_BIT      = 6;

  localparam logic [7:0] COIL_TABLE [4] = '{8'hF5, 8'hF9, 8'hFA, 8'hF6};

  function automatic logic [3:0] coil_nibble(input logic [1:0] idx);
    logic [7:0] entry;
    entry = COIL_TABLE[idx];
    return entry[3:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/spsc_cmd_if.sv @@
// Interface for the command and tick transaction channel.
`timescale 1ns / 1ps
`default_nettype none

interface spsc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] payload;
  logic        clear_counters;

  modport source (output valid, output opcode, output payload, output clear_counters,
                  input ready);
  modport sink (input valid, input opcode, input payload, input clear_counters,
                output ready);
endinterface

`default_nettype wire

@@ rtl/spsc_rsp_if.sv @@
// Interface for the result transaction channel.
`timescale 1ns / 1ps
`default_nettype none

interface spsc_rsp_if;
  logic               valid;
  logic               ready;
  logic [7:0]         port_value;
  logic signed [31:0] steps_remaining;
  logic [31:0]        steps_taken;
  logic               step_pulse;

  modport source (output valid, output port_value, output steps_remaining,
                  output steps_taken, output step_pulse, input ready);
  modport sink (input valid, input port_value, input steps_remaining,
                input steps_taken, input step_pulse, output ready);
endinterface

`default_nettype wire

@@ rtl/spsc_in_stage.sv @@
// Input register stage that captures one command transaction per cycle while the stage is empty or the core advances.
`timescale 1ns / 1ps
`default_nettype none

module spsc_in_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  spsc_cmd_if.sink           cmd_i,
  input  wire logic          adv_i,
  output spsc_pkg::item_t    item_o,
  output logic               valid_o
);
  import spsc_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign cmd_i.ready = !valid_q || adv_i;
  assign item_o      = item_q;
  assign valid_o     = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      item_q.opcode         <= cmd_i.opcode;
      item_q.payload        <= cmd_i.payload;
      item_q.clear_counters <= cmd_i.clear_counters;
    end
  end

endmodule

`default_nettype wire

@@ rtl/spsc_core.sv @@
// Controller state, single-pass update logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module spsc_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  spsc_pkg::item_t    item_i,
  input  wire logic          valid_i,
  output logic               adv_o,
  spsc_rsp_if.source         rsp_o
);
  import spsc_pkg::*;

  logic [23:0] tick_q, tick_d, tick_inc;
  logic [23:0] period_q, period_d;
  logic [31:0] target_q, target_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] taken_q, taken_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  port_q, port_d, port_tmp;
  logic        step;
  logic        fire;

  logic        out_valid_q;
  logic [7:0]  out_port_q;
  logic [31:0] out_rem_q;
  logic [31:0] out_taken_q;
  logic        out_pulse_q;

  assign adv_o = !out_valid_q || rsp_o.ready;
  assign fire  = adv_o && valid_i;

  always_comb begin
    tick_d   = tick_q;
    period_d = period_q;
    target_d = target_q;
    rem_d    = rem_q;
    taken_d  = taken_q;
    phase_d  = phase_q;
    port_d   = port_q;
    port_tmp = port_q;
    step     = 1'b0;
    tick_inc = tick_q + 24'd1;
    case (item_i.opcode)
      OP_TICK: begin
        tick_d = tick_inc;
        if (tick_inc >= period_q) begin
          tick_d = '0;
          if (port_q[RUN_BIT]) begin
            step    = 1'b1;
            taken_d = taken_q + 32'd1;
            rem_d   = target_q - taken_d;
            if (rem_d == 32'd0 || rem_d[31]) begin
              port_tmp[RUN_BIT] = 1'b0;
            end
            port_d = {port_tmp[7:4], coil_nibble(phase_q)};
            if (port_tmp[DIR_BIT]) begin
              phase_d = phase_q + 2'd1;
            end else begin
              phase_d = phase_q - 2'd1;
            end
          end
        end
      end
      OP_PORT_WRITE: begin
        port_d = item_i.payload[7:0];
      end
      OP_SET_PERIOD: begin
        period_d = item_i.payload[23:0];
        tick_d   = '0;
      end
      OP_SET_RUN: begin
        port_d = {item_i.payload[0], port_q[6:0]};
      end
      OP_LOAD_TGT: begin
        target_d = item_i.payload;
        if (item_i.clear_counters) begin
          rem_d   = '0;
          taken_d = '0;
        end else begin
          rem_d = item_i.payload;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q      <= '0;
      period_q    <= PERIOD_RESET;
      target_q    <= '0;
      rem_q       <= '0;
      taken_q     <= '0;
      phase_q     <= '0;
      port_q      <= PORT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_o) begin
        out_valid_q <= valid_i;
      end
      if (fire) begin
        tick_q   <= tick_d;
        period_q <= period_d;
        target_q <= target_d;
        rem_q    <= rem_d;
        taken_q  <= taken_d;
        phase_q  <= phase_d;
        port_q   <= port_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_port_q  <= port_d;
      out_rem_q   <= rem_d;
      out_taken_q <= taken_d;
      out_pulse_q <= step;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.port_value      = out_port_q;
  assign rsp_o.steps_remaining = $signed(out_rem_q);
  assign rsp_o.steps_taken     = out_taken_q;
  assign rsp_o.step_pulse      = out_pulse_q;

  // The tick counter never rests at or above a nonzero period.
  a_tick_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_q == 24'd0) || (tick_q < period_q))
    else $error("tick counter at or above step period");

  // A step that leaves the motor running leaves a positive remaining count.
  a_run_implies_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_pulse_q && out_port_q[RUN_BIT]) |-> ($signed(out_rem_q) > 0))
    else $error("motor still running with no steps remaining");

  // Each step advances the taken count by exactly one.
  a_step_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && step) |=> (taken_q == $past(taken_q) + 32'd1))
    else $error("step did not advance taken count");

  // A step needs a tick transaction and a set run bit.
  a_step_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> (item_i.opcode == OP_TICK && port_q[RUN_BIT]))
    else $error("step without tick or while stopped");

endmodule

`default_nettype wire

@@ rtl/stepper_pump_step_controller.sv @@
// Top level of the four-phase stepper step controller.
// Path: an accepted command transaction is held in the input register, passes the state update
// and its result is then held in the result register until the result transaction is taken.
// Throughput: one transaction per cycle; the state update sits between the input register and
// the result register, and both stages advance whenever the result register is empty or taken.
// Reset: asynchronous, active low; period 520, port 0x80, all counters and phase zero.
`timescale 1ns / 1ps
`default_nettype none

module stepper_pump_step_controller (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spsc_cmd_if.sink   cmd_i,
  spsc_rsp_if.source rsp_o
);
  import spsc_pkg::*;

  item_t item;
  logic  item_valid;
  logic  adv;

  spsc_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .adv_i   (adv),
    .item_o  (item),
    .valid_o (item_valid)
  );

  spsc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item),
    .valid_i (item_valid),
    .adv_o   (adv),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

@@ tb/stepper_pump_step_controller_tb.sv @@
// Self-checking testbench for the stepper step controller: directed and random commands and ticks.
`timescale 1ns / 1ps

import spsc_pkg::*;

typedef struct packed {
  logic [7:0]         port_value;
  logic signed [31:0] steps_remaining;
  logic [31:0]        steps_taken;
  logic               step_pulse;
} motor_status_t;

class step_scoreboard;
  logic [23:0]   tick_count;
  logic [23:0]   step_period;
  logic [31:0]   step_target;
  logic [31:0]   remaining;
  logic [31:0]   taken;
  logic [1:0]    phase;
  logic [7:0]    port_reg;
  motor_status_t pending_status[$];
  int unsigned   failures;

  function new();
    tick_count  = '0;
    step_period = 24'd520;
    step_target = '0;
    remaining   = '0;
    taken       = '0;
    phase       = '0;
    port_reg    = 8'h80;
    failures    = 0;
  endfunction

  function logic [7:0] coil_pattern(logic [1:0] idx);
    case (idx)
      2'd0: return 8'hF5;
      2'd1: return 8'hF9;
      2'd2: return 8'hFA;
      default: return 8'hF6;
    endcase
  endfunction

  function void note_failure(string what);
    failures++;
    if (failures <= 10) $display("[%0t] %s", $time, what);
  endfunction

  // Advances the predicted motor state by one accepted transaction.
  function void accept_command(logic [2:0] op, logic [31:0] payload, logic clr);
    motor_status_t want;
    logic          pulse;
    pulse = 1'b0;
    case (op)
      OP_TICK: begin
        tick_count = tick_count + 24'd1;
        if (tick_count >= step_period) begin
          tick_count = '0;
          if (port_reg[7]) begin
            taken     = taken + 32'd1;
            remaining = step_target - taken;
            if (remaining == 32'd0 || remaining[31]) port_reg[7] = 1'b0;
            port_reg = (port_reg | 8'h0F) & coil_pattern(phase);
            phase    = port_reg[6] ? phase + 2'd1 : phase - 2'd1;
            pulse    = 1'b1;
          end
        end
      end
      OP_PORT_WRITE: port_reg = payload[7:0];
      OP_SET_PERIOD: begin
        step_period = payload[23:0];
        tick_count  = '0;
      end
      OP_SET_RUN: port_reg[7] = payload[0];
      OP_LOAD_TGT: begin
        step_target = payload;
        if (clr) begin
          remaining = '0;
          taken     = '0;
        end else begin
          remaining = payload;
        end
      end
      default: ;
    endcase
    want.port_value      = port_reg;
    want.steps_remaining = remaining;
    want.steps_taken     = taken;
    want.step_pulse      = pulse;
    pending_status.push_back(want);
  endfunction

  function void check_response(motor_status_t got);
    motor_status_t want;
    if (pending_status.size() == 0) begin
      note_failure($sformatf("unexpected result: port %h remaining %0d taken %0d pulse %b",
                             got.port_value, got.steps_remaining, got.steps_taken,
                             got.step_pulse));
      return;
    end
    want = pending_status.pop_front();
    if (got.port_value !== want.port_value || got.steps_remaining !== want.steps_remaining ||
        got.steps_taken !== want.steps_taken || got.step_pulse !== want.step_pulse) begin
      note_failure({$sformatf("mismatch: expected port %h remaining %0d taken %0d pulse %b",
                              want.port_value, want.steps_remaining, want.steps_taken,
                              want.step_pulse),
                    $sformatf(", got port %h remaining %0d taken %0d pulse %b",
                              got.port_value, got.steps_remaining, got.steps_taken,
                              got.step_pulse)});
    end
  endfunction

  function int unsigned pending_count();
    return pending_status.size();
  endfunction

  function void flag_leftovers();
    if (pending_status.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", pending_status.size()));
  endfunction
endclass

module stepper_pump_step_controller_tb;
  localparam logic [2:0]  OP_RESERVED_6 = 3'd6;
  localparam logic [2:0]  OP_RESERVED_7 = 3'd7;
  localparam int unsigned RANDOM_ITEMS  = 1800;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES  = 10;

  logic clk;
  logic rst_n;
  bit   send_burst;
  bit   recv_burst;

  step_scoreboard sb;

  spsc_cmd_if cmd_ch ();
  spsc_rsp_if rsp_ch ();

  stepper_pump_step_controller dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_command(logic [2:0] op, logic [31:0] payload, logic clr);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_ch.valid          <= 1'b1;
    cmd_ch.opcode         <= op;
    cmd_ch.payload        <= payload;
    cmd_ch.clear_counters <= clr;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.accept_command(op, payload, clr);
  endtask

  task automatic wait_for_results();
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_command(OP_NOP, 32'h0, 1'b0);
    send_command(OP_RESERVED_6, 32'hFFFF_FFFF, 1'b1);
    send_command(OP_RESERVED_7, 32'h0, 1'b0);
    send_command(OP_SET_PERIOD, 32'hFF00_0000, 1'b1);
    send_command(OP_LOAD_TGT, 32'd3, 1'b1);
    repeat (4) send_command(OP_TICK, 32'hFFFF_FFFF, 1'b0);
    send_command(OP_PORT_WRITE, 32'hFFFF_FFC0, 1'b0);
    send_command(OP_LOAD_TGT, 32'hFFFF_FFFF, 1'b0);
    send_command(OP_TICK, 32'h0, 1'b1);
    send_command(OP_SET_RUN, 32'hFFFF_FFFF, 1'b0);
    send_command(OP_SET_PERIOD, 32'hFFFF_FFFF, 1'b0);
    send_command(OP_TICK, 32'h0, 1'b0);
    send_command(OP_SET_PERIOD, 32'd2, 1'b0);
    repeat (2) send_command(OP_TICK, 32'h0, 1'b0);
    send_command(OP_SET_RUN, 32'hFFFF_FFFE, 1'b1);
    repeat (2) send_command(OP_TICK, 32'h0, 1'b0);
    send_command(OP_LOAD_TGT, 32'h7FFF_FFFF, 1'b1);
    send_command(OP_PORT_WRITE, 32'h0000_00FF, 1'b1);
    repeat (2) send_command(OP_TICK, 32'h0, 1'b0);
  endtask

  task automatic run_random_traffic(int unsigned count);
    logic [2:0]  op;
    logic [31:0] payload;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait_for_results();
      end
      pick    = $urandom_range(0, 99);
      payload = $urandom;
      if (pick < 55) begin
        op = OP_TICK;
      end else if (pick < 63) begin
        op = OP_PORT_WRITE;
        payload[7] = ($urandom_range(0, 9) < 7);
      end else if (pick < 68) begin
        op = OP_SET_PERIOD;
        if ($urandom_range(0, 19) != 0) payload[23:0] = 24'($urandom_range(0, 4));
      end else if (pick < 76) begin
        op = OP_SET_RUN;
        payload[0] = ($urandom_range(0, 4) != 0);
      end else if (pick < 86) begin
        op = OP_LOAD_TGT;
        if ($urandom_range(0, 9) != 0) payload = 32'($urandom_range(0, 48));
      end else if (pick < 94) begin
        op = OP_NOP;
      end else begin
        op = ($urandom_range(0, 1) != 0) ? OP_RESERVED_6 : OP_RESERVED_7;
      end
      send_command(op, payload, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        @(negedge clk);
        rsp_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      sb.check_response('{rsp_ch.port_value, rsp_ch.steps_remaining, rsp_ch.steps_taken,
                          rsp_ch.step_pulse});
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_n);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("stepper_pump_step_controller regression: fail");
    $finish;
  end

  initial begin
    sb                    = new();
    rst_n                 = 1'b0;
    cmd_ch.valid          = 1'b0;
    cmd_ch.opcode         = '0;
    cmd_ch.payload        = '0;
    cmd_ch.clear_counters = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    run_random_traffic(RANDOM_ITEMS);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.failures == 0) begin
      $display("stepper_pump_step_controller regression: pass");
    end else begin
      $display("stepper_pump_step_controller regression: fail");
    end
    $finish;
  end
endmodule

@@ stepper_pump_step_controller.f @@
rtl/spsc_pkg.sv
rtl/spsc_cmd_if.sv
rtl/spsc_rsp_if.sv
rtl/spsc_in_stage.sv
rtl/spsc_core.sv
rtl/stepper_pump_step_controller.sv
tb/stepper_pump_step_controller_tb.sv
